FILE: src/wheel_speed_and_idle_monitor_assert.svh
// ----------------------------------------------------------------------------
// wheel speed monitor assertion macros
// shared assertion forms used by the port checker
// ----------------------------------------------------------------------------
`ifndef WHEEL_SPEED_AND_IDLE_MONITOR_ASSERT_SVH
`define WHEEL_SPEED_AND_IDLE_MONITOR_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define WSIM_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("wheel speed monitor check failed");

// next-cycle implication, sampled on clk_i, off during reset
`define WSIM_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("wheel speed monitor check failed");

`endif

FILE: src/wsim_pkg.sv
// ----------------------------------------------------------------------------
// wsim_pkg
// types, codes and fixed widths of the wheel speed and idle monitor
// ----------------------------------------------------------------------------
package wsim_pkg;

  // field widths
  localparam int CMD_W      = 2;
  localparam int ADC_W      = 12;
  localparam int SPEED_W    = 14;
  localparam int BRIGHT_W   = 7;
  localparam int DEBOUNCE_W = 10;
  localparam int CIRC_W     = 12;
  localparam int PPR_W      = 5;
  localparam int THRESH_W   = 7;
  localparam int TIMEOUT_W  = 22;
  localparam int CFG_DATA_W = 22;
  localparam int CFG_IDX_W  = 3;

  // quotient bits produced by the serial divider
  localparam int QUO_BITS = 14;

  // register reset values
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = 10'd35;
  localparam logic [CIRC_W-1:0]     CIRC_RST     = 12'd2117;
  localparam logic [PPR_W-1:0]      PPR_RST      = 5'd4;
  localparam logic [THRESH_W-1:0]   THRESH_RST   = 7'd60;
  localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RST  = 22'd10000;

  // arithmetic constants
  localparam logic [SPEED_W-1:0] SPEED_SAT  = 14'd9999;
  localparam logic [SPEED_W-1:0] SLOW_LIMIT = 14'd5;
  localparam logic [ADC_W-1:0]   ADC_FULL   = 12'd4095;
  localparam logic [BRIGHT_W-1:0] PCT_SCALE = 7'd100;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 2'd0,
    CMD_REED    = 2'd1,
    CMD_MEASURE = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE  = 3'd0,
    CFG_CIRC      = 3'd1,
    CFG_PPR       = 3'd2,
    CFG_THRESH    = 3'd3,
    CFG_TIMEOUT   = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SCALE,
    S_START,
    S_DIV,
    S_OUT
  } state_e;

  // controller to datapath commands
  typedef struct packed {
    logic tick;
    logic reed;
    logic snap;
    logic mul;
    logic scale;
    logic div_start;
    logic load_out;
  } ctrl_cmd_t;

endpackage

FILE: src/wsim_in_if.sv
// ----------------------------------------------------------------------------
// wsim_in_if
// command channel: valid/ready with command and light sample
// ----------------------------------------------------------------------------
interface wsim_in_if;
  logic                        valid;
  logic                        ready;
  logic [wsim_pkg::CMD_W-1:0]  command;
  logic [wsim_pkg::ADC_W-1:0]  adc_sample;

  modport source (output valid, output command, output adc_sample, input ready);
  modport sink   (input valid, input command, input adc_sample, output ready);
endinterface

FILE: src/wsim_out_if.sv
// ----------------------------------------------------------------------------
// wsim_out_if
// result channel: valid/ready with speed, brightness and flags
// ----------------------------------------------------------------------------
interface wsim_out_if;
  logic                           valid;
  logic                           ready;
  logic [wsim_pkg::SPEED_W-1:0]   speed_tenths;
  logic [wsim_pkg::BRIGHT_W-1:0]  brightness_pct;
  logic                           light_on;
  logic                           sleep_request;

  modport source (output valid, output speed_tenths, output brightness_pct,
                  output light_on, output sleep_request, input ready);
  modport sink   (input valid, input speed_tenths, input brightness_pct,
                  input light_on, input sleep_request, output ready);
endinterface

FILE: src/wsim_div.sv
// ----------------------------------------------------------------------------
// wsim_div
// serial restoring divider, one quotient bit a cycle, saturating result
// ----------------------------------------------------------------------------
module wsim_div #(
  parameter int NUM_W = 34,
  parameter int DEN_W = 37
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [NUM_W-1:0]              num_i,
  input  logic [DEN_W-1:0]              den_i,
  output logic                          done_o,
  output logic [wsim_pkg::SPEED_W-1:0]  quo_o
);

  localparam int QB     = wsim_pkg::QUO_BITS;
  localparam int DW     = (NUM_W > DEN_W + QB) ? NUM_W : DEN_W + QB;
  localparam int STEP_W = $clog2(QB + 1);

  logic              busy_q, busy_d;
  logic              chk_q, chk_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [DW-1:0]     rem_q, rem_d;
  logic [DW-1:0]     dsh_q, dsh_d;
  logic [QB-1:0]     quo_q, quo_d;
  logic              ovf_q, ovf_d;
  logic              zero_q, zero_d;
  logic              fits;

  assign fits = (rem_q >= dsh_q);

  always_comb begin
    busy_d = busy_q;
    chk_d  = chk_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quo_d  = quo_q;
    ovf_d  = ovf_q;
    zero_d = zero_q;
    if (start_i) begin
      busy_d = 1'b1;
      chk_d  = 1'b1;
      step_d = STEP_W'(QB);
      rem_d  = DW'(num_i);
      dsh_d  = DW'(den_i) << QB;
      quo_d  = '0;
      zero_d = (den_i == '0);
    end else if (busy_q && chk_q) begin
      // quotient would not fit in the result bits
      ovf_d = fits;
      chk_d = 1'b0;
      dsh_d = dsh_q >> 1;
    end else if (busy_q) begin
      if (fits) begin
        rem_d = rem_q - dsh_q;
      end
      quo_d  = {quo_q[QB-2:0], fits};
      dsh_d  = dsh_q >> 1;
      step_d = step_q - STEP_W'(1);
      if (step_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      chk_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      chk_q  <= chk_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dsh_q  <= dsh_d;
    quo_q  <= quo_d;
    ovf_q  <= ovf_d;
    zero_q <= zero_d;
  end

  always_comb begin
    if (zero_q) begin
      quo_o = '0;
    end else if (ovf_q || (quo_q > wsim_pkg::SPEED_SAT)) begin
      quo_o = wsim_pkg::SPEED_SAT;
    end else begin
      quo_o = quo_q;
    end
  end

  assign done_o = done_q;

endmodule

FILE: src/wsim_dp.sv
// ----------------------------------------------------------------------------
// wsim_dp
// datapath: time and pulse state, config registers, speed and light maths
// ----------------------------------------------------------------------------
module wsim_dp #(
  parameter int TIME_WIDTH  = 32,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  wsim_pkg::ctrl_cmd_t               cmd_i,
  input  logic [wsim_pkg::ADC_W-1:0]        adc_sample_i,
  input  logic                              cfg_we_i,
  input  logic [wsim_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [wsim_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  output logic                              div_done_o,
  output logic [wsim_pkg::SPEED_W-1:0]      speed_tenths_o,
  output logic [wsim_pkg::BRIGHT_W-1:0]     brightness_pct_o,
  output logic                              light_on_o,
  output logic                              sleep_request_o
);

  localparam int NUM_W   = COUNT_WIDTH + wsim_pkg::CIRC_W;
  localparam int NUM36_W = NUM_W + 6;
  localparam int DEN_W   = TIME_WIDTH + wsim_pkg::PPR_W;
  localparam int CMP_W   = (TIME_WIDTH > wsim_pkg::TIMEOUT_W) ? TIME_WIDTH
                                                              : wsim_pkg::TIMEOUT_W;
  localparam int PROD_W  = wsim_pkg::ADC_W + 7;
  localparam int BW      = wsim_pkg::BRIGHT_W;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  // configuration
  logic [wsim_pkg::DEBOUNCE_W-1:0] debounce_q;
  logic [wsim_pkg::CIRC_W-1:0]     circ_q;
  logic [wsim_pkg::PPR_W-1:0]      ppr_q;
  logic [wsim_pkg::THRESH_W-1:0]   thresh_q;
  logic [wsim_pkg::TIMEOUT_W-1:0]  timeout_q;

  // architectural state
  logic [TIME_WIDTH-1:0]  time_q, time_d;
  logic [TIME_WIDTH-1:0]  last_edge_q, last_edge_d;
  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic [TIME_WIDTH-1:0]  istart_q, istart_d;
  logic [TIME_WIDTH-1:0]  mark_q, mark_d;

  // measure snapshot and working registers
  logic [COUNT_WIDTH-1:0] cnt_snap_q;
  logic [TIME_WIDTH-1:0]  elapsed_q;
  logic                   idle_q;
  logic [PROD_W-1:0]      prod_q;
  logic [NUM_W-1:0]       num_q;
  logic [DEN_W-1:0]       den_q;
  logic [BW-1:0]          bq0_q;
  logic [NUM36_W-1:0]     num36_q;
  logic [BW-1:0]          bright_q;

  // result register
  logic [wsim_pkg::SPEED_W-1:0] speed_q;
  logic [BW-1:0]                bright_out_q;
  logic                         light_q;
  logic                         sleep_q;

  logic [TIME_WIDTH-1:0]        edge_gap, elapsed, idle_gap;
  logic                         debounced, idle_long;
  logic [PROD_W:0]              bsum;
  logic [PROD_W-1:0]            brem;
  logic [wsim_pkg::SPEED_W-1:0] div_quo;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= wsim_pkg::DEBOUNCE_RST;
      circ_q     <= wsim_pkg::CIRC_RST;
      ppr_q      <= wsim_pkg::PPR_RST;
      thresh_q   <= wsim_pkg::THRESH_RST;
      timeout_q  <= wsim_pkg::TIMEOUT_RST;
    end else if (cfg_we_i) begin
      unique case (wsim_pkg::cfg_idx_e'(cfg_idx_i))
        wsim_pkg::CFG_DEBOUNCE: debounce_q <= cfg_wdata_i[wsim_pkg::DEBOUNCE_W-1:0];
        wsim_pkg::CFG_CIRC:     circ_q     <= cfg_wdata_i[wsim_pkg::CIRC_W-1:0];
        wsim_pkg::CFG_PPR:      ppr_q      <= cfg_wdata_i[wsim_pkg::PPR_W-1:0];
        wsim_pkg::CFG_THRESH:   thresh_q   <= cfg_wdata_i[wsim_pkg::THRESH_W-1:0];
        wsim_pkg::CFG_TIMEOUT:  timeout_q  <= cfg_wdata_i[wsim_pkg::TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  // wrapping time differences
  assign edge_gap  = time_q - last_edge_q;
  assign elapsed   = time_q - istart_q;
  assign idle_gap  = time_q - mark_q;
  assign debounced = CMP_W'(edge_gap) > CMP_W'(debounce_q);
  assign idle_long = CMP_W'(idle_gap) > CMP_W'(timeout_q);

  always_comb begin
    time_d      = time_q;
    last_edge_d = last_edge_q;
    count_d     = count_q;
    istart_d    = istart_q;
    mark_d      = mark_q;
    if (cmd_i.tick) begin
      time_d = time_q + TIME_WIDTH'(1);
    end
    if (cmd_i.reed) begin
      if (debounced && (count_q != COUNT_MAX)) begin
        count_d = count_q + COUNT_WIDTH'(1);
      end
      last_edge_d = time_q;
    end
    if (cmd_i.snap) begin
      if (count_q != '0) begin
        mark_d = time_q;
      end
      istart_d = time_q;
      count_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q      <= '0;
      last_edge_q <= '0;
      count_q     <= '0;
      istart_q    <= '0;
      mark_q      <= '0;
    end else begin
      time_q      <= time_d;
      last_edge_q <= last_edge_d;
      count_q     <= count_d;
      istart_q    <= istart_d;
      mark_q      <= mark_d;
    end
  end

  // brightness: divide by 4095 via x*(1 + 2^-12)/2^12, then one correction
  assign bsum = (PROD_W + 1)'(prod_q) + (PROD_W + 1)'(prod_q >> 12);
  assign brem = prod_q - PROD_W'(bq0_q) * PROD_W'(wsim_pkg::ADC_FULL);

  always_ff @(posedge clk_i) begin
    if (cmd_i.snap) begin
      cnt_snap_q <= count_q;
      elapsed_q  <= elapsed;
      idle_q     <= idle_long;
      prod_q     <= PROD_W'(adc_sample_i) * PROD_W'(wsim_pkg::PCT_SCALE);
    end
    if (cmd_i.mul) begin
      num_q <= NUM_W'(cnt_snap_q) * NUM_W'(circ_q);
      den_q <= DEN_W'(ppr_q) * DEN_W'(elapsed_q);
      bq0_q <= BW'(bsum >> 12);
    end
    if (cmd_i.scale) begin
      // times 36 as 32 + 4
      num36_q  <= (NUM36_W'(num_q) << 5) + (NUM36_W'(num_q) << 2);
      bright_q <= (brem >= PROD_W'(wsim_pkg::ADC_FULL)) ? bq0_q + BW'(1) : bq0_q;
    end
    if (cmd_i.load_out) begin
      speed_q      <= div_quo;
      bright_out_q <= bright_q;
      light_q      <= (bright_q < thresh_q);
      sleep_q      <= idle_q && (div_quo < wsim_pkg::SLOW_LIMIT);
    end
  end

  wsim_div #(
    .NUM_W (NUM36_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (num36_q),
    .den_i   (den_q),
    .done_o  (div_done_o),
    .quo_o   (div_quo)
  );

  assign speed_tenths_o   = speed_q;
  assign brightness_pct_o = bright_out_q;
  assign light_on_o       = light_q;
  assign sleep_request_o  = sleep_q;

endmodule

FILE: src/wsim_ctrl.sv
// ----------------------------------------------------------------------------
// wsim_ctrl
// controller: command decode, measure sequencing and result handshake
// ----------------------------------------------------------------------------
module wsim_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic [wsim_pkg::CMD_W-1:0]    in_command_i,
  output logic                          in_ready_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  input  logic                          div_done_i,
  output wsim_pkg::ctrl_cmd_t           cmd_o
);

  wsim_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             slot_free;
  logic             is_measure;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign is_measure = (wsim_pkg::cmd_e'(in_command_i) == wsim_pkg::CMD_MEASURE);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wsim_pkg::S_IDLE:  if (in_valid_i && is_measure) state_d = wsim_pkg::S_MUL;
      wsim_pkg::S_MUL:   state_d = wsim_pkg::S_SCALE;
      wsim_pkg::S_SCALE: state_d = wsim_pkg::S_START;
      wsim_pkg::S_START: state_d = wsim_pkg::S_DIV;
      wsim_pkg::S_DIV:   if (div_done_i) state_d = wsim_pkg::S_OUT;
      wsim_pkg::S_OUT:   if (slot_free) state_d = wsim_pkg::S_IDLE;
      default:           state_d = wsim_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      wsim_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (wsim_pkg::cmd_e'(in_command_i))
            wsim_pkg::CMD_TICK:    cmd_o.tick = 1'b1;
            wsim_pkg::CMD_REED:    cmd_o.reed = 1'b1;
            wsim_pkg::CMD_MEASURE: cmd_o.snap = 1'b1;
            default: ;
          endcase
        end
      end
      wsim_pkg::S_MUL:   cmd_o.mul       = 1'b1;
      wsim_pkg::S_SCALE: cmd_o.scale     = 1'b1;
      wsim_pkg::S_START: cmd_o.div_start = 1'b1;
      wsim_pkg::S_DIV: ;
      wsim_pkg::S_OUT:   cmd_o.load_out  = slot_free;
      default: ;
    endcase
  end

  always_comb begin
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wsim_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: src/wheel_speed_and_idle_monitor.sv
// ----------------------------------------------------------------------------
// wheel_speed_and_idle_monitor
// reed pulse speedometer with light sensing and idle detection
// ----------------------------------------------------------------------------
// tick and reed commands are taken back to back while the controller is idle
// a measure steps through the multiply, scale, divider start and divide states,
// then waits in its output state until the result register is free, taking no
// command meanwhile; the serial divider makes one overflow check, then one
// quotient bit a cycle; commands flow while a loaded result awaits its transfer
// reset clears time, pulse and mark state to zero and loads the register defaults
module wheel_speed_and_idle_monitor #(
  parameter int TIME_WIDTH  = 32,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  wsim_in_if.sink                           in_if,
  wsim_out_if.source                        out_if,
  input  logic                              cfg_we_i,
  input  logic [wsim_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [wsim_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);

  // command bundle from the sequencer to the datapath
  wsim_pkg::ctrl_cmd_t ctrl_cmd;
  // divider finished, quotient held until the result load
  logic                div_done;

  // controller: accepts one command a cycle while idle, runs the measure
  // sequence and owns the result valid flag
  wsim_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_if.valid),
    .in_command_i (in_if.command),
    .in_ready_o   (in_if.ready),
    .out_ready_i  (out_if.ready),
    .out_valid_o  (out_if.valid),
    .div_done_i   (div_done),
    .cmd_o        (ctrl_cmd)
  );

  // datapath: millisecond clock, debounced pulse count, interval and
  // activity marks, speed division, brightness scaling and result register
  wsim_dp #(
    .TIME_WIDTH  (TIME_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (ctrl_cmd),
    .adc_sample_i     (in_if.adc_sample),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .div_done_o       (div_done),
    .speed_tenths_o   (out_if.speed_tenths),
    .brightness_pct_o (out_if.brightness_pct),
    .light_on_o       (out_if.light_on),
    .sleep_request_o  (out_if.sleep_request)
  );

endmodule

FILE: src/wsim_chk.sv
// ----------------------------------------------------------------------------
// wsim_chk
// port-level checker for the wheel speed monitor, bound to the top level
// ----------------------------------------------------------------------------
`include "wheel_speed_and_idle_monitor_assert.svh"

module wsim_chk (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_ready_i,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic [wsim_pkg::SPEED_W-1:0]   speed_tenths_i,
  input logic [wsim_pkg::BRIGHT_W-1:0]  brightness_pct_i,
  input logic                           sleep_request_i
);

  // stalled result keeps its speed and brightness
`WSIM_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i,
                  out_valid_i && $stable(speed_tenths_i) && $stable(brightness_pct_i))

  // results stay within their saturation limits
`WSIM_ASSERT_IMPL(a_out_range, out_valid_i,
                  speed_tenths_i <= wsim_pkg::SPEED_SAT &&
                  brightness_pct_i <= wsim_pkg::PCT_SCALE)

  // sleep only when slow
`WSIM_ASSERT_IMPL(a_sleep_slow, out_valid_i && sleep_request_i,
                  speed_tenths_i < wsim_pkg::SLOW_LIMIT)

  // a new result appears only while command transfers are held off
`WSIM_ASSERT_IMPL(a_rise_busy, $rose(out_valid_i), !$past(in_ready_i))

endmodule

bind wheel_speed_and_idle_monitor wsim_chk u_wsim_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_ready_i       (in_if.ready),
  .out_valid_i      (out_if.valid),
  .out_ready_i      (out_if.ready),
  .speed_tenths_i   (out_if.speed_tenths),
  .brightness_pct_i (out_if.brightness_pct),
  .sleep_request_i  (out_if.sleep_request)
);

FILE: tb/wheel_speed_and_idle_monitor_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wheel_speed_and_idle_monitor_tb
// self-checking bench: drives tick, reed and measure commands in bursts with
// random gaps, stalls the result side on its own pattern, predicts every
// report in a scoreboard and compares each result transfer field by field
// ----------------------------------------------------------------------------
module wheel_speed_and_idle_monitor_tb;

  localparam int TIME_W         = 32;
  localparam int COUNT_W        = 16;
  localparam logic [wsim_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;
  localparam int SETTLE_CYCLES  = 40;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_ITEMS   = 600;
  localparam int N_PHASES       = 8;
  localparam int PRESSURE_PHASE = 4;

  typedef struct packed {
    logic [wsim_pkg::SPEED_W-1:0]  speed;
    logic [wsim_pkg::BRIGHT_W-1:0] bright;
    logic                          light;
    logic                          sleep;
  } report_t;

  // predicts reports from the accepted commands and checks the result transfers
  class speedo_scoreboard;
    logic [wsim_pkg::DEBOUNCE_W-1:0] debounce;
    logic [wsim_pkg::CIRC_W-1:0]     circ;
    logic [wsim_pkg::PPR_W-1:0]      ppr;
    logic [wsim_pkg::THRESH_W-1:0]   thresh;
    logic [wsim_pkg::TIMEOUT_W-1:0]  timeout;
    logic [TIME_W-1:0]     now_ms, last_edge_ms, interval_ms, mark_ms;
    logic [COUNT_W-1:0]    pulses;
    report_t               due_reports[$];
    int                    errors;

    function new();
      debounce     = wsim_pkg::DEBOUNCE_RST;
      circ         = wsim_pkg::CIRC_RST;
      ppr          = wsim_pkg::PPR_RST;
      thresh       = wsim_pkg::THRESH_RST;
      timeout      = wsim_pkg::TIMEOUT_RST;
      now_ms       = '0;
      last_edge_ms = '0;
      interval_ms  = '0;
      mark_ms      = '0;
      pulses       = '0;
      errors       = 0;
    endfunction

    function void set_reg(wsim_pkg::cfg_idx_e idx, logic [wsim_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        wsim_pkg::CFG_DEBOUNCE: debounce = val[wsim_pkg::DEBOUNCE_W-1:0];
        wsim_pkg::CFG_CIRC:     circ     = val[wsim_pkg::CIRC_W-1:0];
        wsim_pkg::CFG_PPR:      ppr      = val[wsim_pkg::PPR_W-1:0];
        wsim_pkg::CFG_THRESH:   thresh   = val[wsim_pkg::THRESH_W-1:0];
        wsim_pkg::CFG_TIMEOUT:  timeout  = val[wsim_pkg::TIMEOUT_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_command(logic [wsim_pkg::CMD_W-1:0] cmd,
                               logic [wsim_pkg::ADC_W-1:0] adc);
      logic [TIME_W-1:0] since_edge, elapsed, idle;
      logic [63:0]       num, den, quo;
      logic [31:0]       pct;
      report_t           rep;
      since_edge = now_ms - last_edge_ms;
      elapsed    = now_ms - interval_ms;
      idle       = now_ms - mark_ms;
      case (cmd)
        wsim_pkg::CMD_TICK: now_ms = now_ms + 1'b1;
        wsim_pkg::CMD_REED: begin
          // every reed edge moves the edge time, also one that is not counted
          if (since_edge > TIME_W'(debounce) && pulses != '1) pulses = pulses + 1'b1;
          last_edge_ms = now_ms;
        end
        wsim_pkg::CMD_MEASURE: begin
          num = 64'(pulses) * 64'(circ) * 64'd36;
          den = 64'(ppr) * 64'(elapsed);
          quo = (den == 64'd0) ? 64'd0 : num / den;
          if (quo > 64'(wsim_pkg::SPEED_SAT)) quo = 64'(wsim_pkg::SPEED_SAT);
          pct        = (32'(adc) * 32'(wsim_pkg::PCT_SCALE)) / 32'(wsim_pkg::ADC_FULL);
          rep.speed  = quo[wsim_pkg::SPEED_W-1:0];
          rep.bright = pct[wsim_pkg::BRIGHT_W-1:0];
          rep.light  = (rep.bright < thresh);
          // sleep uses the activity mark from before this measure
          rep.sleep  = (rep.speed < wsim_pkg::SLOW_LIMIT) && (idle > TIME_W'(timeout));
          due_reports.push_back(rep);
          if (pulses != '0) mark_ms = now_ms;
          interval_ms = now_ms;
          pulses      = '0;
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $time);
      errors++;
    endtask

    task check_result(report_t got);
      report_t want;
      if (due_reports.size() == 0) begin
        report_mismatch("result with none due, speed_tenths", got.speed, 0);
        return;
      end
      want = due_reports.pop_front();
      if (got.speed !== want.speed) report_mismatch("speed_tenths", got.speed, want.speed);
      if (got.bright !== want.bright) report_mismatch("brightness_pct", got.bright, want.bright);
      if (got.light !== want.light) report_mismatch("light_on", got.light, want.light);
      if (got.sleep !== want.sleep) report_mismatch("sleep_request", got.sleep, want.sleep);
    endtask
  endclass

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [wsim_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [wsim_pkg::CFG_DATA_W-1:0] cfg_wdata_i;

  wsim_in_if  cmd_ch ();
  wsim_out_if res_ch ();

  speedo_scoreboard sb;

  // sender burst state and receiver stall pattern
  bit          gaps_on     = 1'b0;
  int          burst_left  = 0;
  int          stall_mode  = 0;
  int          stall_left  = 0;
  int          holds_asked = 0;
  int          holds_done  = 0;
  int unsigned quiet_cycles = 0;

  wheel_speed_and_idle_monitor #(
    .TIME_WIDTH  (TIME_W),
    .COUNT_WIDTH (COUNT_W)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (cmd_ch),
    .out_if      (res_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  // result side: random stalls, or one long hold-off when asked
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (holds_done != holds_asked) begin
        holds_done++;
        res_ch.ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else if (stall_left > 0) begin
        res_ch.ready = 1'b0;
        stall_left--;
      end else if (stall_mode != 0 && $urandom_range(0, 15) < 3 * stall_mode) begin
        res_ch.ready = 1'b0;
        stall_left   = $urandom_range(0, 6 * stall_mode);
      end else begin
        res_ch.ready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_ch.valid && res_ch.ready)
      sb.check_result(report_t'({res_ch.speed_tenths, res_ch.brightness_pct,
                                 res_ch.light_on, res_ch.sleep_request}));
  end

  // ends the run when no transfer happens for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [wsim_pkg::ADC_W-1:0] pick_adc();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return wsim_pkg::ADC_FULL;
      default: return wsim_pkg::ADC_W'($urandom_range(0, 4095));
    endcase
  endfunction

  // entered and left at a falling edge
  task automatic send_cmd(input logic [wsim_pkg::CMD_W-1:0] cmd,
                          input logic [wsim_pkg::ADC_W-1:0] adc);
    int gap;
    if (gaps_on && burst_left == 0) begin
      burst_left   = $urandom_range(1, 20);
      gap          = $urandom_range(1, 10);
      cmd_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cmd_ch.valid      = 1'b1;
    cmd_ch.command    = cmd;
    cmd_ch.adc_sample = adc;
    do @(posedge clk_i); while (!cmd_ch.ready);
    sb.note_command(cmd, adc);
    if (burst_left > 0) burst_left--;
    @(negedge clk_i);
  endtask

  task automatic write_reg(input wsim_pkg::cfg_idx_e idx,
                           input logic [wsim_pkg::CFG_DATA_W-1:0] val);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = val;
    sb.set_reg(idx, val);
    @(negedge clk_i);
  endtask

  task automatic apply_settings(input logic [wsim_pkg::CFG_DATA_W-1:0] deb, circ, ppr,
                                thr, tmo);
    write_reg(wsim_pkg::CFG_DEBOUNCE, deb);
    write_reg(wsim_pkg::CFG_CIRC, circ);
    write_reg(wsim_pkg::CFG_PPR, ppr);
    write_reg(wsim_pkg::CFG_THRESH, thr);
    write_reg(wsim_pkg::CFG_TIMEOUT, tmo);
    cfg_we_i = 1'b0;
  endtask

  // drain every due report, then let a tick or reed still in flight finish
  task automatic settle();
    cmd_ch.valid = 1'b0;
    while (sb.due_reports.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // mostly a ride interval closed by a measure, sometimes idling or noise
  task automatic ride_segment(output int counted);
    int kind, n, r;
    counted = 0;
    kind    = $urandom_range(0, 9);
    if (kind < 7) begin
      n = $urandom_range(2, 24);
      repeat (n) begin
        r = $urandom_range(0, 19);
        if (r < 11) begin
          send_cmd(wsim_pkg::CMD_TICK, pick_adc());
          counted++;
        end else if (r < 18) begin
          send_cmd(wsim_pkg::CMD_REED, pick_adc());
          counted++;
        end else if (r == 18) begin
          // early measure cuts the interval short
          send_cmd(wsim_pkg::CMD_MEASURE, pick_adc());
          counted++;
        end else begin
          send_cmd(CMD_SPARE, pick_adc());
        end
      end
      send_cmd(wsim_pkg::CMD_MEASURE, pick_adc());
      counted++;
    end else if (kind < 9) begin
      // wheel standing still, so the idle timeout can run out
      n = $urandom_range(5, 60);
      repeat (n) send_cmd(wsim_pkg::CMD_TICK, pick_adc());
      send_cmd(wsim_pkg::CMD_MEASURE, pick_adc());
      counted = n + 1;
    end else begin
      n = $urandom_range(1, 6);
      repeat (n) begin
        r = $urandom_range(0, 3);
        send_cmd(wsim_pkg::CMD_W'(r), pick_adc());
        if (wsim_pkg::CMD_W'(r) != CMD_SPARE) counted++;
      end
    end
  endtask

  initial begin
    int sent, n;
    rst_ni            = 1'b0;
    cmd_ch.valid      = 1'b0;
    cmd_ch.command    = wsim_pkg::CMD_TICK;
    cmd_ch.adc_sample = '0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = wsim_pkg::CFG_DEBOUNCE;
    cfg_wdata_i       = '0;
    sb = new();
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (3) @(negedge clk_i);

    // register defaults: zero elapsed and both ends of the light sample
    send_cmd(wsim_pkg::CMD_MEASURE, '0);
    send_cmd(wsim_pkg::CMD_MEASURE, wsim_pkg::ADC_FULL);
    settle();

    // directed: debounce, zero elapsed with pulses, threshold edge, sleep
    apply_settings(3, 2117, 4, 60, 5);
    send_cmd(wsim_pkg::CMD_MEASURE, 12'd2457);
    send_cmd(wsim_pkg::CMD_MEASURE, 12'd2456);
    send_cmd(wsim_pkg::CMD_REED, wsim_pkg::ADC_FULL);
    repeat (4) send_cmd(wsim_pkg::CMD_TICK, '0);
    send_cmd(wsim_pkg::CMD_REED, '0);
    send_cmd(wsim_pkg::CMD_REED, '0);
    send_cmd(wsim_pkg::CMD_MEASURE, 12'd2048);
    repeat (4) send_cmd(wsim_pkg::CMD_TICK, '0);
    send_cmd(wsim_pkg::CMD_MEASURE, 12'd1000);
    send_cmd(wsim_pkg::CMD_REED, '0);
    send_cmd(wsim_pkg::CMD_MEASURE, 12'd3000);
    send_cmd(CMD_SPARE, wsim_pkg::ADC_FULL);
    repeat (6) send_cmd(wsim_pkg::CMD_TICK, '0);
    send_cmd(wsim_pkg::CMD_MEASURE, 12'd1);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      settle();
      if (ph == 0) begin
        apply_settings(10'h3FF, 12'hFFF, 5'h1F, 7'h7F, 22'h3FFFFF);
      end else if (ph == 1) begin
        apply_settings(0, 0, 0, 0, 0);
      end else begin
        apply_settings(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                   : $urandom_range(0, 6),
                       $urandom_range(1, 4095),
                       ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 31),
                       $urandom_range(0, 127),
                       ($urandom_range(0, 4) == 0) ? $urandom_range(0, 22'h3FFFFF)
                                                   : $urandom_range(0, 60));
      end
      gaps_on    = ($urandom_range(0, 2) != 0);
      burst_left = 0;
      stall_mode = $urandom_range(0, 2);
      if (ph == PRESSURE_PHASE) begin
        // long result hold-off while commands keep coming
        gaps_on = 1'b0;
        holds_asked++;
      end
      sent = 0;
      while (sent < RANDOM_ITEMS / N_PHASES) begin
        ride_segment(n);
        sent += n;
      end
    end

    settle();
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
